// ===== src/hmcs_pkg.sv =====
// ----------------------------------------------------------------------------
// Heat map color scale package
// Shared widths, payload structs, register map and result codes.
// ----------------------------------------------------------------------------
package hmcs_pkg;

  // Width of a sample and of the range bounds (signed Q16.16).
  localparam int unsigned VALUE_WIDTH = 32;
  // Fraction bits of the blend factor; one divider stage per bit.
  localparam int unsigned FACTOR_BITS = 16;
  localparam int unsigned COLOR_WIDTH = 32;
  localparam int unsigned CHAN_WIDTH  = 8;
  localparam int unsigned NUM_CHANS   = 3;

  localparam int unsigned APB_DATA_WIDTH = 32;
  localparam int unsigned APB_ADDR_WIDTH = 5;

  localparam logic [COLOR_WIDTH-1:0] LOW_COLOR_RST  = 32'hFF00_00FF;
  localparam logic [COLOR_WIDTH-1:0] HIGH_COLOR_RST = 32'hFFFF_0000;
  localparam logic [COLOR_WIDTH-1:0] CLEAR_COLOR    = 32'h0000_0000;
  localparam logic [CHAN_WIDTH-1:0]  ALPHA_OPAQUE   = 8'hFF;
  localparam logic [CHAN_WIDTH-1:0]  ALPHA_CLEAR    = 8'h00;

  // Register indexes; byte address is four times the index.
  typedef enum logic [2:0] {
    REG_CENTER_TRANSPARENT = 3'd0,
    REG_RANGE_LOW          = 3'd1,
    REG_RANGE_HIGH         = 3'd2,
    REG_LOW_COLOR          = 3'd3,
    REG_HIGH_COLOR         = 3'd4
  } reg_idx_e;

  // How the final color of an item is formed.
  typedef enum logic [2:0] {
    KIND_ERROR,
    KIND_LOW,
    KIND_LOW_RGB,
    KIND_HIGH,
    KIND_CLEAR,
    KIND_BLEND
  } kind_e;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] sample;
    logic                          sample_valid;
    logic                          range_valid;
  } in_item_t;

  typedef struct packed {
    logic [COLOR_WIDTH-1:0] color;
    logic                   error;
  } out_item_t;

endpackage

// ===== src/heat_map_color_scale.sv =====
// ----------------------------------------------------------------------------
// Heat map color scale
// Pipelined mapping of signed Q16.16 samples to ARGB colors.
// ----------------------------------------------------------------------------
// Usage:
//   Samples arrive on the input channel (in_valid_i / in_ready_o) as one
//   in_item_t per transfer; colors leave on the output channel
//   (out_valid_o / out_ready_i) as one out_item_t per transfer, in order.
//   The thresholds, the two colors and the mode are set through the APB
//   port, by the user only while no item is in flight; the block itself
//   does not enforce this. Throughput is one item per cycle while the
//   skid register is empty. The pipeline is an input register, a decode
//   stage, sixteen restoring divider stages (one quotient bit each, each
//   a 33-bit subtract and compare), a multiply stage and the output
//   register. The divider chain for the blend factor sets this depth.
//   When the receiver stalls, one extra result lands in a skid register
//   and the pipeline freezes only once that register is full, so
//   in_ready_o is a plain register output and nothing is lost or repeated.
//   Reset (asynchronous, active low) empties the pipeline and loads the
//   register defaults: transparent-center mode, both bounds zero, blue as
//   the low color and red as the high color.
// ----------------------------------------------------------------------------
module heat_map_color_scale (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Input channel.
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  hmcs_pkg::in_item_t                     in_item_i,
  // Output channel.
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output hmcs_pkg::out_item_t                    out_item_o,
  // Configuration port.
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [hmcs_pkg::APB_ADDR_WIDTH-1:0]    paddr,
  input  logic [hmcs_pkg::APB_DATA_WIDTH-1:0]    pwdata,
  output logic [hmcs_pkg::APB_DATA_WIDTH-1:0]    prdata,
  output logic                                   pready
);

  localparam int unsigned W  = hmcs_pkg::VALUE_WIDTH;
  localparam int unsigned F  = hmcs_pkg::FACTOR_BITS;
  localparam int unsigned CW = hmcs_pkg::CHAN_WIDTH;
  localparam int unsigned NC = hmcs_pkg::NUM_CHANS;

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  logic                                 center_q;
  logic signed [W-1:0]                  range_low_q;
  logic signed [W-1:0]                  range_high_q;
  logic [hmcs_pkg::COLOR_WIDTH-1:0]     low_color_q;
  logic [hmcs_pkg::COLOR_WIDTH-1:0]     high_color_q;
  hmcs_pkg::reg_idx_e                   reg_idx;
  logic                                 cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = hmcs_pkg::reg_idx_e'(paddr[hmcs_pkg::APB_ADDR_WIDTH-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q     <= 1'b1;
      range_low_q  <= '0;
      range_high_q <= '0;
      low_color_q  <= hmcs_pkg::LOW_COLOR_RST;
      high_color_q <= hmcs_pkg::HIGH_COLOR_RST;
    end else if (cfg_write) begin
      unique case (reg_idx)
        hmcs_pkg::REG_CENTER_TRANSPARENT: center_q     <= pwdata[0];
        hmcs_pkg::REG_RANGE_LOW:          range_low_q  <= pwdata;
        hmcs_pkg::REG_RANGE_HIGH:         range_high_q <= pwdata;
        hmcs_pkg::REG_LOW_COLOR:          low_color_q  <= pwdata;
        hmcs_pkg::REG_HIGH_COLOR:         high_color_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      hmcs_pkg::REG_CENTER_TRANSPARENT:
        prdata = {{(hmcs_pkg::APB_DATA_WIDTH-1){1'b0}}, center_q};
      hmcs_pkg::REG_RANGE_LOW:  prdata = range_low_q;
      hmcs_pkg::REG_RANGE_HIGH: prdata = range_high_q;
      hmcs_pkg::REG_LOW_COLOR:  prdata = low_color_q;
      hmcs_pkg::REG_HIGH_COLOR: prdata = high_color_q;
      default:                  prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline control. Every stage advances while the skid register is empty.
  // --------------------------------------------------------------------------
  logic skid_valid_q;
  logic out_valid_q;
  logic advance;
  logic in_accept;

  assign advance    = !skid_valid_q;
  assign in_ready_o = advance;
  assign in_accept  = in_valid_i && in_ready_o;

  // --------------------------------------------------------------------------
  // Stage registers.
  // --------------------------------------------------------------------------
  logic                 in_valid_q;
  hmcs_pkg::in_item_t   in_item_q;

  // Index 0 is the decode stage; index k holds k quotient bits.
  logic                 div_valid_q [F+1];
  hmcs_pkg::kind_e      div_kind_q  [F+1];
  logic [W-1:0]         div_rem_q   [F+1];
  logic [W-1:0]         div_den_q   [F+1];
  logic [F-1:0]         div_quo_q   [F+1];
  logic [W-1:0]         div_rem_d   [F+1];
  logic [F-1:0]         div_quo_d   [F+1];

  logic                 mul_valid_q;
  hmcs_pkg::kind_e      mul_kind_q;
  logic [CW+F-1:0]      hi_prod_q [NC];
  logic [CW+F:0]        lo_prod_q [NC];

  // --------------------------------------------------------------------------
  // Decode: classify the sample and form the divider operands.
  // --------------------------------------------------------------------------
  hmcs_pkg::kind_e      dec_kind;
  logic signed [W:0]    dec_num_wide;
  logic signed [W:0]    dec_den_wide;

  always_comb begin
    if (!in_item_q.sample_valid || !in_item_q.range_valid) begin
      dec_kind = hmcs_pkg::KIND_ERROR;
    end else if (center_q) begin
      if (in_item_q.sample < range_low_q) begin
        dec_kind = hmcs_pkg::KIND_LOW;
      end else if (in_item_q.sample > range_high_q) begin
        dec_kind = hmcs_pkg::KIND_HIGH;
      end else begin
        dec_kind = hmcs_pkg::KIND_CLEAR;
      end
    end else begin
      if (in_item_q.sample >= range_high_q) begin
        dec_kind = hmcs_pkg::KIND_HIGH;
      end else if (in_item_q.sample < range_low_q) begin
        dec_kind = hmcs_pkg::KIND_LOW_RGB;
      end else begin
        dec_kind = hmcs_pkg::KIND_BLEND;
      end
    end
    // Exact differences. When blending, the numerator is nonnegative and
    // below the denominator, which always fits in W unsigned bits.
    dec_num_wide = {in_item_q.sample[W-1], in_item_q.sample}
                 - {range_low_q[W-1], range_low_q};
    dec_den_wide = {range_high_q[W-1], range_high_q}
                 - {range_low_q[W-1], range_low_q};
  end

  // --------------------------------------------------------------------------
  // Restoring divider: each stage shifts the remainder and tries the divisor.
  // --------------------------------------------------------------------------
  always_comb begin
    logic [W:0] shifted;
    logic       take;
    div_rem_d[0] = '0;
    div_quo_d[0] = '0;
    for (int k = 0; k < F; k++) begin
      shifted        = {div_rem_q[k], 1'b0};
      take           = shifted >= {1'b0, div_den_q[k]};
      div_rem_d[k+1] = take ? W'(shifted - {1'b0, div_den_q[k]}) : W'(shifted);
      div_quo_d[k+1] = {div_quo_q[k][F-2:0], take};
    end
  end

  // --------------------------------------------------------------------------
  // Blend multiplies: high channel times f, low channel times (1 - f).
  // --------------------------------------------------------------------------
  logic [F-1:0] factor;
  logic [F:0]   inv_factor;

  assign factor     = div_quo_q[F];
  assign inv_factor = {1'b1, {F{1'b0}}} - {1'b0, factor};

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      mul_valid_q <= 1'b0;
      for (int k = 0; k <= F; k++) begin
        div_valid_q[k] <= 1'b0;
      end
    end else if (advance) begin
      in_valid_q     <= in_accept;
      div_valid_q[0] <= in_valid_q;
      for (int k = 0; k < F; k++) begin
        div_valid_q[k+1] <= div_valid_q[k];
      end
      mul_valid_q <= div_valid_q[F];
    end
  end

  // Payload; no reset needed.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      in_item_q     <= in_item_i;
      div_kind_q[0] <= dec_kind;
      div_rem_q[0]  <= dec_num_wide[W-1:0];
      div_den_q[0]  <= dec_den_wide[W-1:0];
      div_quo_q[0]  <= div_quo_d[0];
      for (int k = 0; k < F; k++) begin
        div_kind_q[k+1] <= div_kind_q[k];
        div_rem_q[k+1]  <= div_rem_d[k+1];
        div_den_q[k+1]  <= div_den_q[k];
        div_quo_q[k+1]  <= div_quo_d[k+1];
      end
      mul_kind_q <= div_kind_q[F];
      for (int c = 0; c < NC; c++) begin
        hi_prod_q[c] <= high_color_q[CW*c +: CW] * factor;
        lo_prod_q[c] <= low_color_q[CW*c +: CW] * inv_factor;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Final color selection.
  // --------------------------------------------------------------------------
  hmcs_pkg::out_item_t res_item;

  always_comb begin
    logic [CW+F:0]   chan_sum;
    logic [CW*NC-1:0] blend_rgb;
    for (int c = 0; c < NC; c++) begin
      chan_sum                = {1'b0, hi_prod_q[c]} + lo_prod_q[c];
      blend_rgb[CW*c +: CW]   = chan_sum[F +: CW];
    end
    res_item.error = 1'b0;
    case (mul_kind_q)
      hmcs_pkg::KIND_ERROR: begin
        res_item.color = hmcs_pkg::CLEAR_COLOR;
        res_item.error = 1'b1;
      end
      hmcs_pkg::KIND_LOW:     res_item.color = low_color_q;
      hmcs_pkg::KIND_LOW_RGB: res_item.color = {hmcs_pkg::ALPHA_CLEAR, low_color_q[CW*NC-1:0]};
      hmcs_pkg::KIND_HIGH:    res_item.color = high_color_q;
      hmcs_pkg::KIND_CLEAR:   res_item.color = hmcs_pkg::CLEAR_COLOR;
      hmcs_pkg::KIND_BLEND:   res_item.color = {hmcs_pkg::ALPHA_OPAQUE, blend_rgb};
      default:                res_item.color = hmcs_pkg::CLEAR_COLOR;
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register with a skid register behind it.
  // --------------------------------------------------------------------------
  hmcs_pkg::out_item_t out_item_q;
  hmcs_pkg::out_item_t skid_item_q;
  logic                out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!skid_valid_q) begin
      if (out_free) begin
        out_valid_q <= mul_valid_q;
      end else if (mul_valid_q) begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_ready_i) begin
      skid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_valid_q) begin
      if (out_free) begin
        out_item_q <= res_item;
      end else begin
        skid_item_q <= res_item;
      end
    end else if (out_ready_i) begin
      out_item_q <= skid_item_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== src/hmcs_checker.sv =====
// ----------------------------------------------------------------------------
// Heat map color scale checker
// Port-level assertions on the output buffering and error coding.
// ----------------------------------------------------------------------------
module hmcs_checker (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  input  logic                                   in_ready_o,
  input  hmcs_pkg::in_item_t                     in_item_i,
  input  logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  input  hmcs_pkg::out_item_t                    out_item_o,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [hmcs_pkg::APB_ADDR_WIDTH-1:0]    paddr,
  input  logic [hmcs_pkg::APB_DATA_WIDTH-1:0]    pwdata,
  input  logic [hmcs_pkg::APB_DATA_WIDTH-1:0]    prdata,
  input  logic                                   pready
);

  // An error result always carries a cleared color.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.error |-> out_item_o.color == hmcs_pkg::CLEAR_COLOR)
    else $error("error result with nonzero color");

  // Input back-pressure only occurs while a result waits at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with an empty output");

  // The input side stops only after the receiver refused a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(out_valid_o && !out_ready_i))
    else $error("input stalled without an output stall");

  // A stalled result stays and keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result dropped or changed");

endmodule

bind heat_map_color_scale hmcs_checker u_hmcs_checker (.*);
